[src/sct_pkg.sv]
// shared codes, character constants and byte classifiers for the source tokenizer
`default_nettype none
package sct_pkg;

  // scanner modes
  typedef enum logic [3:0] {
    MODE_IDLE    = 4'd0,
    MODE_NAME    = 4'd1,
    MODE_NUMBER  = 4'd2,
    MODE_OPER    = 4'd3,
    MODE_STRING  = 4'd4,
    MODE_HASH    = 4'd5,
    MODE_LINECOM = 4'd6,
    MODE_BLOCK   = 4'd7
  } mode_t;

  // pending operator codes
  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_MINUS = 3'd1;
  localparam logic [2:0] OP_EQ    = 3'd2;
  localparam logic [2:0] OP_BANG  = 3'd3;
  localparam logic [2:0] OP_GT    = 3'd4;
  localparam logic [2:0] OP_LT    = 3'd5;

  // token kinds
  localparam logic [4:0] KIND_LPAREN  = 5'd0;
  localparam logic [4:0] KIND_RPAREN  = 5'd1;
  localparam logic [4:0] KIND_LBRACE  = 5'd2;
  localparam logic [4:0] KIND_RBRACE  = 5'd3;
  localparam logic [4:0] KIND_COMMA   = 5'd4;
  localparam logic [4:0] KIND_SEMI    = 5'd5;
  localparam logic [4:0] KIND_DOT     = 5'd6;
  localparam logic [4:0] KIND_COLON   = 5'd7;
  localparam logic [4:0] KIND_PLUS    = 5'd8;
  localparam logic [4:0] KIND_SLASH   = 5'd9;
  localparam logic [4:0] KIND_STAR    = 5'd10;
  localparam logic [4:0] KIND_OP_BASE = 5'd9;
  localparam logic [4:0] KIND_STRING  = 5'd21;
  localparam logic [4:0] KIND_NUMBER  = 5'd22;
  localparam logic [4:0] KIND_NAME    = 5'd23;
  localparam logic [4:0] KIND_EOF     = 5'd24;
  localparam logic [4:0] KIND_BADCHAR = 5'd25;
  localparam logic [4:0] KIND_UNTERM  = 5'd26;

  localparam logic [15:0] LEN_MAX = 16'hFFFF;

  // characters
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR);
  endfunction

  // one-byte punctuation: {hit, kind}
  function automatic logic [5:0] single_kind(input logic [7:0] c);
    logic [5:0] r;
    case (c)
      8'h28: r = {1'b1, KIND_LPAREN};
      8'h29: r = {1'b1, KIND_RPAREN};
      8'h7B: r = {1'b1, KIND_LBRACE};
      8'h7D: r = {1'b1, KIND_RBRACE};
      8'h2C: r = {1'b1, KIND_COMMA};
      8'h3B: r = {1'b1, KIND_SEMI};
      8'h2E: r = {1'b1, KIND_DOT};
      8'h3A: r = {1'b1, KIND_COLON};
      8'h2B: r = {1'b1, KIND_PLUS};
      8'h2F: r = {1'b1, KIND_SLASH};
      8'h2A: r = {1'b1, KIND_STAR};
      default: r = 6'd0;
    endcase
    return r;
  endfunction

  // operators that may take a second byte
  function automatic logic [2:0] oper_code(input logic [7:0] c);
    logic [2:0] r;
    case (c)
      CH_MINUS: r = OP_MINUS;
      CH_EQ:    r = OP_EQ;
      CH_BANG:  r = OP_BANG;
      CH_GT:    r = OP_GT;
      CH_LT:    r = OP_LT;
      default:  r = OP_NONE;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[src/sct_if.sv]
// valid/ready channel interfaces for source bytes and tokens
`default_nettype none
interface sct_char_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] char_byte;

  modport source(output valid, action, char_byte, input ready);
  modport sink(input valid, action, char_byte, output ready);
endinterface

interface sct_tok_if #(
  parameter int OFFSET_BITS = 20,
  parameter int LINE_BITS   = 16
);
  logic                   valid;
  logic                   ready;
  logic [4:0]             token_kind;
  logic [OFFSET_BITS-1:0] start_offset;
  logic [15:0]            token_length;
  logic [LINE_BITS-1:0]   start_line;
  logic [LINE_BITS-1:0]   start_column;
  logic [LINE_BITS-1:0]   end_line;
  logic [LINE_BITS-1:0]   end_column;
  logic                   last_of_run;

  modport source(output valid, token_kind, start_offset, token_length, start_line,
                 start_column, end_line, end_column, last_of_run, input ready);
  modport sink(input valid, token_kind, start_offset, token_length, start_line,
               start_column, end_line, end_column, last_of_run, output ready);
endinterface
`default_nettype wire

[src/sct_tok_fifo.sv]
// four-entry token queue that takes up to two tokens per cycle while two entries are free
`default_nettype none
module sct_tok_fifo #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [1:0]       push_cnt,
  input  wire logic [WIDTH-1:0] push_d0,
  input  wire logic [WIDTH-1:0] push_d1,
  output logic                  room,
  output logic                  rd_valid,
  input  wire logic             rd_ready,
  output logic [WIDTH-1:0]      rd_data
);

  logic [WIDTH-1:0] mem [4];
  logic [1:0]       wr_ptr;
  logic [1:0]       rd_ptr;
  logic [2:0]       count;
  logic             pop;

  // room for two more tokens, regardless of this cycle's pop
  assign room     = (count <= 3'd2);
  assign rd_valid = (count != 3'd0);
  assign rd_data  = mem[rd_ptr];
  assign pop      = rd_valid && rd_ready;

  // storage
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[wr_ptr] <= push_d0;
    end
    if (push_cnt == 2'd2) begin
      mem[wr_ptr + 2'd1] <= push_d1;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr + push_cnt;
      rd_ptr <= rd_ptr + {1'b0, pop};
      count  <= count + {1'b0, push_cnt} - {2'b00, pop};
    end
  end

  // a push never lands on a full queue
  assert property (@(posedge clk) disable iff (rst) (push_cnt != 2'd0) |-> room)
    else $error("token pushed without room");
  assert property (@(posedge clk) disable iff (rst) count <= 3'd4)
    else $error("token queue overflow");
  assert property (@(posedge clk) disable iff (rst)
      (push_cnt == 2'd0) && pop |=> count == $past(count) - 3'd1)
    else $error("token queue count lost a pop");

endmodule
`default_nettype wire

[src/source_char_tokenizer.sv]
// streaming tokenizer top level: input register, scanner state and token queue
//
// Takes one source byte (or an end item) per cycle and gives tokens with kind, start
// offset, length and start/end line and column. An accepted item is held in an input
// register and scanned, once the queue has room, by single-pass logic that updates the
// scanner state and writes zero, one or two tokens into a four-entry output queue;
// tokens pass the input register and the queue before they appear. Input rate is one
// item per cycle as long as the output side keeps up; a byte that ends a name, number
// or operator and itself forms a one-byte token (and an end item that flushes a pending
// token) gives two tokens, which leave one at a time, so the sustained rate is bounded
// by one token per cycle at the output port. The scanner stalls while more than two tokens wait.
`default_nettype none
module source_char_tokenizer #(
  parameter int OFFSET_BITS = 20,
  parameter int LINE_BITS   = 16
) (
  input wire logic  clk,
  input wire logic  rst,
  sct_char_if.sink  char_in,
  sct_tok_if.source tok_out
);

  localparam int OB     = OFFSET_BITS;
  localparam int LB     = LINE_BITS;
  localparam int CW     = ((OB > LB) ? OB : LB) + 1;
  localparam int LW     = (OB > 16) ? OB : 16;
  localparam int BODY_W = 5 + OB + 16 + 4 * LB;
  localparam int TOK_W  = BODY_W + 1;

  // column of an offset on the current line, saturating
  function automatic logic [LB-1:0] col_of(input logic [OB-1:0] off,
                                           input logic [OB-1:0] ls);
    logic [OB-1:0] d;
    logic [CW-1:0] dw;
    d  = (off >= ls) ? (off - ls) : '0;
    dw = CW'(d);
    return (dw >= CW'({LB{1'b1}})) ? {LB{1'b1}} : LB'(dw + CW'(1));
  endfunction

  // token length, saturating at 16 bits
  function automatic logic [15:0] len_of(input logic [OB-1:0] e, input logic [OB-1:0] s);
    logic [OB-1:0] d;
    logic [LW-1:0] dw;
    d  = (e >= s) ? (e - s) : '0;
    dw = LW'(d);
    return (dw > LW'(sct_pkg::LEN_MAX)) ? sct_pkg::LEN_MAX : dw[15:0];
  endfunction

  function automatic logic [BODY_W-1:0] make_tok(
    input logic [4:0]    kind,
    input logic [OB-1:0] s_off,
    input logic [LB-1:0] s_line,
    input logic [LB-1:0] s_col,
    input logic [OB-1:0] e_off,
    input logic [LB-1:0] e_line,
    input logic [OB-1:0] ls
  );
    return {kind, s_off, len_of(e_off, s_off), s_line, s_col, e_line, col_of(e_off, ls)};
  endfunction

  // input register
  logic       q_valid;
  logic       q_action;
  logic [7:0] q_byte;
  logic       fire;
  logic       fifo_room;

  // scanner state
  sct_pkg::mode_t scan_mode, scan_mode_next;
  logic [LB-1:0]  line_count, line_count_next;
  logic [OB-1:0]  line_start_offset, line_start_offset_next;
  logic [OB-1:0]  byte_offset, byte_offset_next;
  logic [OB-1:0]  token_start_offset, token_start_offset_next;
  logic [LB-1:0]  token_start_line, token_start_line_next;
  logic [LB-1:0]  token_start_column, token_start_column_next;
  logic [2:0]     pending_operator, pending_operator_next;
  logic           hash_seen, hash_seen_next;
  logic           error_halt, error_halt_next;

  // tokens of this step: a closes the running token, b is the one started by this byte or the end-of-file token
  logic              a_v, b_v;
  logic [BODY_W-1:0] a_tok, b_tok;
  logic [1:0]        push_cnt;
  logic [TOK_W-1:0]  push_d0, push_d1;
  logic [TOK_W-1:0]  rd_data;

  assign fire          = q_valid && fifo_room;
  assign char_in.ready = !q_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (char_in.ready) begin
      q_valid <= char_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_in.valid && char_in.ready) begin
      q_action <= char_in.action;
      q_byte   <= char_in.char_byte;
    end
  end

  // scan step
  always_comb begin
    logic [OB-1:0] p;
    logic [OB-1:0] bo_inc;
    logic [LB-1:0] lc_inc;
    logic          do_fresh;
    logic [2:0]    op_eff;
    logic [7:0]    second;
    logic [4:0]    okind;
    logic [5:0]    sk;
    logic [2:0]    op_new;

    scan_mode_next          = scan_mode;
    line_count_next         = line_count;
    line_start_offset_next  = line_start_offset;
    byte_offset_next        = byte_offset;
    token_start_offset_next = token_start_offset;
    token_start_line_next   = token_start_line;
    token_start_column_next = token_start_column;
    pending_operator_next   = pending_operator;
    hash_seen_next          = hash_seen;
    error_halt_next         = error_halt;
    a_v      = 1'b0;
    b_v      = 1'b0;
    a_tok    = '0;
    b_tok    = '0;
    do_fresh = 1'b0;
    p        = byte_offset;
    bo_inc   = (byte_offset == {OB{1'b1}}) ? byte_offset : byte_offset + OB'(1);
    lc_inc   = (line_count == {LB{1'b1}}) ? line_count : line_count + LB'(1);
    op_eff   = ((pending_operator >= sct_pkg::OP_MINUS) &&
                (pending_operator <= sct_pkg::OP_LT)) ? pending_operator : sct_pkg::OP_MINUS;
    second   = (op_eff == sct_pkg::OP_MINUS) ? sct_pkg::CH_GT : sct_pkg::CH_EQ;
    okind    = 5'({op_eff, 1'b0}) + sct_pkg::KIND_OP_BASE;
    sk       = sct_pkg::single_kind(q_byte);
    op_new   = sct_pkg::oper_code(q_byte);

    if (fire) begin
      if (q_action) begin
        // end item: flush, end-of-file token, back to reset state
        if (!error_halt) begin
          case (scan_mode)
            sct_pkg::MODE_NAME: begin
              a_v = 1'b1;
              a_tok = make_tok(sct_pkg::KIND_NAME, token_start_offset, token_start_line,
                               token_start_column, byte_offset, line_count,
                               line_start_offset);
            end
            sct_pkg::MODE_NUMBER: begin
              a_v = 1'b1;
              a_tok = make_tok(sct_pkg::KIND_NUMBER, token_start_offset, token_start_line,
                               token_start_column, byte_offset, line_count,
                               line_start_offset);
            end
            sct_pkg::MODE_OPER: begin
              a_v = (pending_operator >= sct_pkg::OP_MINUS) &&
                    (pending_operator <= sct_pkg::OP_LT);
              a_tok = make_tok(okind, token_start_offset, token_start_line,
                               token_start_column, byte_offset, line_count,
                               line_start_offset);
            end
            sct_pkg::MODE_STRING: begin
              a_v = 1'b1;
              a_tok = make_tok(sct_pkg::KIND_UNTERM, token_start_offset, token_start_line,
                               token_start_column, byte_offset, line_count,
                               line_start_offset);
            end
            default: begin
              a_v = 1'b0;
            end
          endcase
        end
        b_v = 1'b1;
        b_tok = make_tok(sct_pkg::KIND_EOF, byte_offset, line_count,
                         col_of(byte_offset, line_start_offset), byte_offset, line_count,
                         line_start_offset);
        scan_mode_next          = sct_pkg::MODE_IDLE;
        line_count_next         = LB'(1);
        line_start_offset_next  = '0;
        byte_offset_next        = '0;
        token_start_offset_next = '0;
        token_start_line_next   = LB'(1);
        token_start_column_next = LB'(1);
        pending_operator_next   = sct_pkg::OP_NONE;
        hash_seen_next          = 1'b0;
        error_halt_next         = 1'b0;
      end else if (!error_halt) begin
        byte_offset_next = bo_inc;
        case (scan_mode)
          sct_pkg::MODE_NAME: begin
            if (!(sct_pkg::is_letter(q_byte) || sct_pkg::is_digit(q_byte))) begin
              a_v = 1'b1;
              a_tok = make_tok(sct_pkg::KIND_NAME, token_start_offset, token_start_line,
                               token_start_column, p, line_count, line_start_offset);
              do_fresh = 1'b1;
            end
          end
          sct_pkg::MODE_NUMBER: begin
            if (!sct_pkg::is_digit(q_byte)) begin
              a_v = 1'b1;
              a_tok = make_tok(sct_pkg::KIND_NUMBER, token_start_offset, token_start_line,
                               token_start_column, p, line_count, line_start_offset);
              do_fresh = 1'b1;
            end
          end
          sct_pkg::MODE_OPER: begin
            pending_operator_next = sct_pkg::OP_NONE;
            a_v = 1'b1;
            if (q_byte == second) begin
              scan_mode_next = sct_pkg::MODE_IDLE;
              a_tok = make_tok(okind + 5'd1, token_start_offset, token_start_line,
                               token_start_column, bo_inc, line_count, line_start_offset);
            end else begin
              a_tok = make_tok(okind, token_start_offset, token_start_line,
                               token_start_column, p, line_count, line_start_offset);
              do_fresh = 1'b1;
            end
          end
          sct_pkg::MODE_STRING: begin
            if (q_byte == sct_pkg::CH_QUOTE) begin
              scan_mode_next = sct_pkg::MODE_IDLE;
              a_v = 1'b1;
              a_tok = make_tok(sct_pkg::KIND_STRING, token_start_offset, token_start_line,
                               token_start_column, bo_inc, line_count, line_start_offset);
            end else if (q_byte == sct_pkg::CH_NL) begin
              line_count_next        = lc_inc;
              line_start_offset_next = bo_inc;
            end
          end
          sct_pkg::MODE_HASH: begin
            if (q_byte == sct_pkg::CH_HASH) begin
              scan_mode_next = sct_pkg::MODE_BLOCK;
              hash_seen_next = 1'b0;
            end else if (q_byte == sct_pkg::CH_NL) begin
              scan_mode_next         = sct_pkg::MODE_IDLE;
              line_count_next        = lc_inc;
              line_start_offset_next = bo_inc;
            end else begin
              scan_mode_next = sct_pkg::MODE_LINECOM;
            end
          end
          sct_pkg::MODE_LINECOM: begin
            if (q_byte == sct_pkg::CH_NL) begin
              scan_mode_next         = sct_pkg::MODE_IDLE;
              line_count_next        = lc_inc;
              line_start_offset_next = bo_inc;
            end
          end
          sct_pkg::MODE_BLOCK: begin
            if (q_byte == sct_pkg::CH_HASH) begin
              if (hash_seen) begin
                scan_mode_next = sct_pkg::MODE_IDLE;
                hash_seen_next = 1'b0;
              end else begin
                hash_seen_next = 1'b1;
              end
            end else begin
              hash_seen_next = 1'b0;
              if (q_byte == sct_pkg::CH_NL) begin
                line_count_next        = lc_inc;
                line_start_offset_next = bo_inc;
              end
            end
          end
          default: begin
            do_fresh = 1'b1;
          end
        endcase

        // this byte opens a new token
        if (do_fresh) begin
          token_start_offset_next = p;
          token_start_line_next   = line_count;
          token_start_column_next = col_of(p, line_start_offset);
          scan_mode_next          = sct_pkg::MODE_IDLE;
          if (sct_pkg::is_blank(q_byte)) begin
            scan_mode_next = sct_pkg::MODE_IDLE;
          end else if (q_byte == sct_pkg::CH_NL) begin
            line_count_next        = lc_inc;
            line_start_offset_next = bo_inc;
          end else if (q_byte == sct_pkg::CH_HASH) begin
            scan_mode_next = sct_pkg::MODE_HASH;
          end else if (sk[5]) begin
            b_v = 1'b1;
            b_tok = make_tok(sk[4:0], p, line_count, col_of(p, line_start_offset), bo_inc,
                             line_count, line_start_offset);
          end else if (op_new != sct_pkg::OP_NONE) begin
            pending_operator_next = op_new;
            scan_mode_next        = sct_pkg::MODE_OPER;
          end else if (q_byte == sct_pkg::CH_QUOTE) begin
            scan_mode_next = sct_pkg::MODE_STRING;
          end else if (sct_pkg::is_digit(q_byte)) begin
            scan_mode_next = sct_pkg::MODE_NUMBER;
          end else if (sct_pkg::is_letter(q_byte)) begin
            scan_mode_next = sct_pkg::MODE_NAME;
          end else begin
            error_halt_next = 1'b1;
            b_v = 1'b1;
            b_tok = make_tok(sct_pkg::KIND_BADCHAR, p, line_count,
                             col_of(p, line_start_offset), bo_inc, line_count,
                             line_start_offset);
          end
        end
      end
    end
  end

  // scanner state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode          <= sct_pkg::MODE_IDLE;
      line_count         <= LB'(1);
      line_start_offset  <= '0;
      byte_offset        <= '0;
      token_start_offset <= '0;
      token_start_line   <= LB'(1);
      token_start_column <= LB'(1);
      pending_operator   <= sct_pkg::OP_NONE;
      hash_seen          <= 1'b0;
      error_halt         <= 1'b0;
    end else begin
      scan_mode          <= scan_mode_next;
      line_count         <= line_count_next;
      line_start_offset  <= line_start_offset_next;
      byte_offset        <= byte_offset_next;
      token_start_offset <= token_start_offset_next;
      token_start_line   <= token_start_line_next;
      token_start_column <= token_start_column_next;
      pending_operator   <= pending_operator_next;
      hash_seen          <= hash_seen_next;
      error_halt         <= error_halt_next;
    end
  end

  // pack tokens in order, last flag on the final one
  assign push_cnt = {1'b0, a_v} + {1'b0, b_v};
  assign push_d0  = a_v ? {a_tok, !b_v} : {b_tok, 1'b1};
  assign push_d1  = {b_tok, 1'b1};

  sct_tok_fifo #(
    .WIDTH(TOK_W)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push_cnt (push_cnt),
    .push_d0  (push_d0),
    .push_d1  (push_d1),
    .room     (fifo_room),
    .rd_valid (tok_out.valid),
    .rd_ready (tok_out.ready),
    .rd_data  (rd_data)
  );

  assign {tok_out.token_kind, tok_out.start_offset, tok_out.token_length,
          tok_out.start_line, tok_out.start_column, tok_out.end_line,
          tok_out.end_column, tok_out.last_of_run} = rd_data;

  // operator mode always holds a real operator code
  assert property (@(posedge clk) disable iff (rst)
      (scan_mode == sct_pkg::MODE_OPER) |->
      (pending_operator >= sct_pkg::OP_MINUS) && (pending_operator <= sct_pkg::OP_LT))
    else $error("operator mode without pending operator");

  // end item always gives a token and restarts the scanner
  assert property (@(posedge clk) disable iff (rst)
      fire && q_action |-> b_v ##1
      (scan_mode == sct_pkg::MODE_IDLE) && (byte_offset == '0) && !error_halt)
    else $error("end item did not restart scanner");

  // after an error bytes are dropped without moving the offset
  assert property (@(posedge clk) disable iff (rst)
      fire && !q_action && error_halt |-> (push_cnt == 2'd0) ##1
      (error_halt && $stable(byte_offset)))
    else $error("byte scanned after error");

  // a held input item waits unchanged
  assert property (@(posedge clk) disable iff (rst)
      q_valid && !fire |=> q_valid && $stable(q_byte) && $stable(q_action))
    else $error("input register lost a stalled item");

endmodule
`default_nettype wire
